// ===== rtl/acmac_pkg.sv =====
// Package for the AES-128 CMAC unit: S-box, round constants and round helpers.
// Used by acmac_aes_round and the top level aes_cmac_chained_mac_unit.
package acmac_pkg;

  localparam int unsigned BlockBits = 128;

  typedef logic [BlockBits-1:0] block_t;

  typedef enum logic [1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1,
    RegIvHigh  = 2'd2,
    RegIvLow   = 2'd3
  } reg_idx_e;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[BlockBits-1-8*i -: 8];
  endfunction

endpackage

// ===== rtl/acmac_aes_round.sv =====
// One AES-128 round plus the matching key-schedule step, shared by all rounds.
// Depends on acmac_pkg.
module acmac_aes_round import acmac_pkg::*; (
  input  block_t     state_i,
  input  block_t     rkey_i,     // key of the previous round
  input  logic [3:0] round_i,    // 1..10
  output block_t     state_o,
  output block_t     rkey_o      // key of this round
);

  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [31:0] w [4];
  logic [31:0] nw [4];
  logic [31:0] t;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = sbox(get_byte(state_i, i));
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[r + 4*c] = sb[r + 4*((c + r) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] al;
      al = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c]   = sr[4*c]   ^ al ^ xtime(sr[4*c]   ^ sr[4*c+1]);
      mc[4*c+1] = sr[4*c+1] ^ al ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
      mc[4*c+2] = sr[4*c+2] ^ al ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
      mc[4*c+3] = sr[4*c+3] ^ al ^ xtime(sr[4*c+3] ^ sr[4*c]);
    end
    for (int i = 0; i < 4; i++) begin
      w[i] = rkey_i[BlockBits-1-32*i -: 32];
    end
    t = {sbox(w[3][23:16]) ^ rcon(round_i), sbox(w[3][15:8]), sbox(w[3][7:0]),
         sbox(w[3][31:24])};
    nw[0] = w[0] ^ t;
    nw[1] = w[1] ^ nw[0];
    nw[2] = w[2] ^ nw[1];
    nw[3] = w[3] ^ nw[2];
    rkey_o = {nw[0], nw[1], nw[2], nw[3]};
    for (int i = 0; i < 16; i++) begin
      state_o[BlockBits-1-8*i -: 8] = ((round_i == 4'd10) ? sr[i] : mc[i])
                                      ^ rkey_o[BlockBits-1-8*i -: 8];
    end
  end

endmodule

// ===== rtl/aes_cmac_chained_mac_unit.sv =====
// Top level of the AES-128 CMAC unit with a persistent CBC chain.
// Depends on acmac_pkg and acmac_aes_round.
//
//  channel   direction  tdata / tuser
//  s_axis    in         data_high, data_low, valid_bytes / last_chunk, reload_chain
//  m_axis    out        mac
//  apb       cfg        key_high, key_low, iv_high, iv_low at 0x00, 0x08, 0x10, 0x18
//
// For each chunk the load step applies the first round key, then the
// shared round unit runs 10 rounds with the round keys expanded on the fly.
// A last chunk then holds its mac in the output state until it is taken.
// A key write starts a subkey pass that encrypts the zero block.
// s_axis_tready is low while a chunk or a subkey pass runs or a mac waits.
// Reset clears the chain value and the control state.
module aes_cmac_chained_mac_unit import acmac_pkg::*; #(
  parameter int unsigned MAC_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] data_high, [127:64] data_low, [132:128] valid_bytes, rest zero
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_chunk
  input  logic [0:0]   s_axis_tuser,   // [0] reload_chain
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // [63:0] mac
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned OutBytes = (MAC_BYTES > 8) ? 8 : MAC_BYTES;
  localparam logic [63:0] MacMask = ~(64'hffff_ffff_ffff_ffff >> (8 * OutBytes));

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StOut
  } state_e;

  state_e      state_q;
  logic [3:0]  round_q;
  logic        sub_q;       // running the subkey pass
  logic        pend_q;      // key written, subkey pass owed
  logic        last_q;
  block_t      st_q, rk_q;
  block_t      key_q, iv_q, chain_q, k1_q, k2_q;
  logic [63:0] mac_q;

  block_t      st_d, rk_d, msg, padded, din, l_val, k1_d;
  logic [4:0]  vb;
  logic        wr;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[4:3]);

  always_comb begin
    case (reg_idx_e'(paddr[4:3]))
      RegKeyHigh: prdata = key_q[127:64];
      RegKeyLow:  prdata = key_q[63:0];
      RegIvHigh:  prdata = iv_q[127:64];
      RegIvLow:   prdata = iv_q[63:0];
      default:    prdata = '0;
    endcase
  end

  acmac_aes_round u_round (
    .state_i(st_q),
    .rkey_i (rk_q),
    .round_i(round_q),
    .state_o(st_d),
    .rkey_o (rk_d)
  );

  // Message block: tdata low word is data_high (bytes 0..7).
  always_comb begin
    msg = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    vb  = s_axis_tdata[132:128];
    for (int i = 0; i < 16; i++) begin
      if (i < vb) begin
        padded[BlockBits-1-8*i -: 8] = msg[BlockBits-1-8*i -: 8];
      end else if (i == vb) begin
        padded[BlockBits-1-8*i -: 8] = 8'h80;
      end else begin
        padded[BlockBits-1-8*i -: 8] = 8'h00;
      end
    end
    if (!s_axis_tlast) begin
      din = msg;
    end else if (vb >= 5'd16) begin
      din = msg ^ k1_q;
    end else begin
      din = padded ^ k2_q;
    end
    din = din ^ (s_axis_tuser[0] ? iv_q : chain_q);
    l_val = st_d;
    k1_d  = {l_val[126:0], 1'b0} ^ (l_val[127] ? 128'h87 : 128'h0);
  end

  assign s_axis_tready = (state_q == StIdle) && !pend_q && !wr;
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
      sub_q   <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      st_q    <= '0;
      rk_q    <= '0;
      chain_q <= '0;
      key_q   <= '0;
      iv_q    <= '0;
      k1_q    <= '0;
      k2_q    <= '0;
      mac_q   <= '0;
    end else begin
      if (wr) begin
        case (widx)
          RegKeyHigh: begin
            key_q[127:64] <= pwdata;
            pend_q        <= 1'b1;
          end
          RegKeyLow: begin
            key_q[63:0] <= pwdata;
            pend_q      <= 1'b1;
          end
          RegIvHigh: iv_q[127:64] <= pwdata;
          RegIvLow:  iv_q[63:0]   <= pwdata;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (pend_q && !wr) begin
            pend_q  <= 1'b0;
            sub_q   <= 1'b1;
            st_q    <= key_q;
            rk_q    <= key_q;
            round_q <= 4'd1;
            state_q <= StRun;
          end else if (s_axis_tvalid && s_axis_tready) begin
            sub_q   <= 1'b0;
            last_q  <= s_axis_tlast;
            st_q    <= din ^ key_q;
            rk_q    <= key_q;
            round_q <= 4'd1;
            state_q <= StRun;
          end
        end
        StRun: begin
          st_q    <= st_d;
          rk_q    <= rk_d;
          round_q <= round_q + 4'd1;
          if (round_q == 4'd10) begin
            if (sub_q) begin
              k1_q    <= k1_d;
              k2_q    <= {k1_d[126:0], 1'b0} ^ (k1_d[127] ? 128'h87 : 128'h0);
              state_q <= StIdle;
            end else begin
              chain_q <= st_d;
              mac_q   <= st_d[127:64] & MacMask;
              state_q <= last_q ? StOut : StIdle;
            end
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready)
    else $error("input accepted while busy");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (round_q >= 4'd1 && round_q <= 4'd10))
    else $error("round counter out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("mac dropped while stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for aes_cmac_chained_mac_unit (AES-128 CMAC with a chained IV).
// It depends on acmac_pkg for the register indexes. It has its own AES and CMAC
// predictor, random stream stimulus, random stalls on both sides and an APB driver.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acmac_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 30;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  aes_cmac_chained_mac_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  logic [7:0] sbox_lut [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Predictor state: register copies, expanded key, subkeys and the running chain.
  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [127:0] sched_q [11];
  logic [127:0] subkey1_q, subkey2_q, chain_q;

  logic [63:0]  mac_expect_q [$];
  int unsigned  cycle_count = 0;
  int unsigned  fail_count = 0;
  int unsigned  chunks_sent = 0;
  int unsigned  macs_checked = 0;
  bit           steady_flow = 1'b0;
  int unsigned  rx_hold_req = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8] ^ sched_q[0][127-8*i -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) st[i] = sbox_lut[st[i]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[r+4*c] = st[r+4*((c+r)%4)];
      st = tmp;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= sched_q[rnd][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

  // Expands the key into the schedule and derives both CMAC subkeys.
  task automatic rekey();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    logic [127:0] k, l;
    k = {key_hi_q, key_lo_q};
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]], sbox_lut[t[15:8]], sbox_lut[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gmul2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched_q[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    l = aes_encrypt('0);
    subkey1_q = gf_double(l);
    subkey2_q = gf_double(subkey1_q);
  endtask

  // Folds one accepted chunk into the chain and queues the mac on a last chunk.
  task automatic absorb_chunk(input logic [127:0] data, input logic [4:0] vbytes,
                              input bit last, input bit reload);
    logic [127:0] blk;
    int unsigned n;
    blk = data;
    if (reload) chain_q = {iv_hi_q, iv_lo_q};
    if (last) begin
      n = (vbytes >= 16) ? 16 : vbytes;
      if (n == 16) begin
        blk ^= subkey1_q;
      end else begin
        for (int i = 0; i < 16; i++)
          if (i > n) blk[127-8*i -: 8] = 8'h00;
          else if (i == n) blk[127-8*i -: 8] = 8'h80;
        blk ^= subkey2_q;
      end
    end
    chain_q = aes_encrypt(chain_q ^ blk);
    if (last) mac_expect_q = {mac_expect_q, chain_q[127:64]};
  endtask

  task automatic send_chunk(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] vbytes, input bit last, input bit reload);
    int unsigned gap;
    bit acc;
    gap = steady_flow ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, vbytes, lo, hi};
    s_axis_tlast  <= last;
    s_axis_tuser  <= reload;
    do begin
      @(negedge clk_i);
      acc = s_axis_tready;
      @(posedge clk_i);
    end while (!acc);
    absorb_chunk({hi, lo}, vbytes, last, reload);
    chunks_sent++;
  endtask

  // Waits for every mac and for a chunk without a mac to leave the engine.
  task automatic drain();
    if (s_axis_tvalid) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (mac_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegKeyHigh: begin key_hi_q = value; rekey(); end
      RegKeyLow:  begin key_lo_q = value; rekey(); end
      RegIvHigh:  iv_hi_q = value;
      default:    iv_lo_q = value;
    endcase
  endtask

  task automatic program_all(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] ih, input logic [63:0] il);
    write_reg(RegKeyHigh, kh);
    write_reg(RegKeyLow, kl);
    write_reg(RegIvHigh, ih);
    write_reg(RegIvLow, il);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A message of random length; most start with a reload, some carry noise.
  task automatic send_message(input int unsigned nchunks);
    bit reload;
    logic [4:0] vb;
    reload = ($urandom_range(0, 3) != 0);
    for (int unsigned c = 0; c < nchunks; c++) begin
      vb = (c + 1 == nchunks) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) vb = 5'($urandom_range(17, 31));
      send_chunk(rand64(), rand64(), vb, c + 1 == nchunks,
                 (c == 0) ? reload : ($urandom_range(0, 19) == 0));
    end
  endtask

  task automatic test_directed();
    program_all(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0);
    send_chunk('0, '0, 5'd0, 1'b1, 1'b1);                    // empty message
    send_chunk(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1, 1'b1);
    send_chunk('1, '1, 5'd16, 1'b1, 1'b1);
    send_chunk('1, '1, 5'd31, 1'b1, 1'b0);                   // saturates to full
    send_chunk(64'h0123456789abcdef, '1, 5'd5, 1'b1, 1'b0);  // garbage past the valid bytes
    send_chunk('1, '1, 5'd15, 1'b1, 1'b0);
    send_chunk('1, 64'h0, 5'd8, 1'b1, 1'b0);
    send_chunk(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd1, 1'b1, 1'b1);
    // A three-chunk message that reloads the chain on its middle chunk.
    send_chunk(rand64(), rand64(), 5'd31, 1'b0, 1'b1);
    send_chunk(rand64(), rand64(), 5'd0, 1'b0, 1'b1);
    send_chunk(rand64(), rand64(), 5'd10, 1'b1, 1'b0);
    // IV change takes effect only on a reload.
    write_reg(RegIvHigh, '1);
    write_reg(RegIvLow, '1);
    send_chunk(rand64(), rand64(), 5'd16, 1'b1, 1'b0);
    send_chunk(rand64(), rand64(), 5'd16, 1'b1, 1'b1);
    // Key change in the middle of a message.
    send_chunk(rand64(), rand64(), 5'd2, 1'b0, 1'b1);
    write_reg(RegKeyLow, '1);
    send_chunk(rand64(), rand64(), 5'd3, 1'b1, 1'b0);
    write_reg(RegKeyHigh, '1);
    send_chunk('0, '0, 5'd0, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_random_messages(input int unsigned nitems);
    int unsigned start;
    int unsigned n;
    start = chunks_sent;
    while (chunks_sent - start < nitems) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      send_message(n);
      // Short stretches without any idling on the input or output side.
      if ($urandom_range(0, 15) == 0) steady_flow = ~steady_flow;
    end
    steady_flow = 1'b0;
    drain();
  endtask

  task automatic test_backpressure();
    rx_hold_req = 600;
    steady_flow = 1'b1;
    for (int i = 0; i < 20; i++) send_message($urandom_range(1, 3));
    steady_flow = 1'b0;
    drain();
  endtask

  task automatic test_pause_for_drain();
    for (int i = 0; i < 6; i++) begin
      send_message($urandom_range(1, 3));
      drain();
    end
  endtask

  // Output side: random readiness, one draw per mac.
  initial begin
    int unsigned n;
    bit acc;
    forever begin
      n = steady_flow ? 0 : $urandom_range(0, 13);
      if (rx_hold_req != 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        acc = m_axis_tvalid && rst_ni;
        @(posedge clk_i);
      end while (!acc);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mac_expect_q.size() == 0) begin
        $error("mac: none expected, got %h", m_axis_tdata);
        fail_count++;
      end else begin
        if (m_axis_tdata !== mac_expect_q[0]) begin
          $error("mac: expected %h, actual %h", mac_expect_q[0], m_axis_tdata);
          fail_count++;
        end
        void'(mac_expect_q.pop_front());
        macs_checked++;
      end
    end
  end

  initial begin
    key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
    chain_q = '0; subkey1_q = '0; subkey2_q = '0;
    for (int r = 0; r < 11; r++) sched_q[r] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_messages(300);
    program_all('0, '0, '0, '0);
    test_random_messages(300);
    program_all('1, '1, '1, '1);
    test_random_messages(300);
    program_all(rand64(), rand64(), rand64(), rand64());
    test_backpressure();
    test_random_messages(300);
    program_all(rand64(), rand64(), rand64(), rand64());
    test_pause_for_drain();
    test_random_messages(300);
    write_reg(RegIvLow, rand64());
    test_random_messages(250);
    drain();
    if (mac_expect_q.size() != 0) fail_count++;
    $display("Sent %0d chunks and checked %0d macs over several key and IV settings,",
             chunks_sent, macs_checked);
    $display("with random stalls, a long output hold-off and drained pauses.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
